/* src/abtg_pkg.sv */
// Shared constants and types for the airtime budget transmit gate.
package abtg_pkg;

   // Default width of the internal wrapping time base
   localparam int unsigned TIME_BITS_DEF = 32;

   // Field widths fixed by the interface
   localparam int unsigned NOW_W      = 32;
   localparam int unsigned FRAME_W    = 10;
   localparam int unsigned EST_W      = 24;
   localparam int unsigned FACTOR_W   = 4;
   localparam int unsigned MAXLEN_W   = 9;
   localparam int unsigned CSR_DATA_W = 9;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned OUT_TIME_W = 32;

   // Configuration register reset values
   localparam logic [FACTOR_W-1:0] BUDGET_FACTOR_RST = 4'd5;
   localparam logic [MAXLEN_W-1:0] MAX_FRAME_LEN_RST = 9'd255;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET_FACTOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME_LEN = 1'b1;

   // Event flags of one result item
   typedef struct packed {
      logic start_send;
      logic send_finished;
      logic send_timed_out;
      logic drop_oversize;
      logic busy_res;
   } flags_type;

endpackage : abtg_pkg

/* src/airtime_budget_tx_gate_unit.sv */
// Airtime budget transmit gate: one dispatcher poll in, one decision out.
//
//   channel   | ports  | direction | carries
//   ----------+--------+-----------+-----------------------------------------
//   request   | req_*  | in        | one poll: time, radio and queue flags
//   response  | rsp_*  | out       | one decision and airtime figures per poll
//   config    | csr_*  | in        | budget_factor, max_frame_len writes
//
// An accepted request passes through the request register, then through the
// decision logic into the response register. One item is taken every cycle
// while the response side is not stalled; the rate is set by the single pass
// from the request register through the silence product (airtime times a
// 4-bit factor plus the time) into the state and response registers.
// Reset is synchronous and active high; it empties both registers, clears the
// send state and the airtime total and restores the configuration defaults.
// A stalled response holds the request register, and the request side stalls
// only once both are full.
module airtime_budget_tx_gate_unit #(
   parameter int unsigned TIME_BITS = abtg_pkg::TIME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [abtg_pkg::NOW_W-1:0]          req_now_ms,
   input  logic                                req_send_complete,
   input  logic                                req_queue_nonempty,
   input  logic                                req_radio_receiving,
   input  logic                                req_item_ready,
   input  logic [abtg_pkg::FRAME_W-1:0]        req_frame_len,
   input  logic [abtg_pkg::EST_W-1:0]          req_est_airtime_ms,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_start_send,
   output logic                                rsp_send_finished,
   output logic                                rsp_send_timed_out,
   output logic                                rsp_drop_oversize,
   output logic [abtg_pkg::OUT_TIME_W-1:0]     rsp_last_airtime_ms,
   output logic [abtg_pkg::OUT_TIME_W-1:0]     rsp_total_airtime_ms,
   output logic                                rsp_busy_res,
   // configuration port
   input  logic                                csr_we,
   input  logic [abtg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [abtg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned TB     = TIME_BITS;
   localparam int unsigned WIDE_W = 64;
   localparam int unsigned HALF_W = abtg_pkg::EST_W + 1;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [abtg_pkg::FACTOR_W-1:0] budget_factor_ff;
   logic [abtg_pkg::MAXLEN_W-1:0] max_frame_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_factor_ff <= abtg_pkg::BUDGET_FACTOR_RST;
         max_frame_len_ff <= abtg_pkg::MAX_FRAME_LEN_RST;
      end else if (csr_we) begin
         case (csr_index)
            abtg_pkg::CSR_BUDGET_FACTOR: begin
               budget_factor_ff <= csr_wdata[abtg_pkg::FACTOR_W-1:0];
            end
            abtg_pkg::CSR_MAX_FRAME_LEN: begin
               max_frame_len_ff <= csr_wdata[abtg_pkg::MAXLEN_W-1:0];
            end
            default: begin
               // ignore writes to unknown indexes
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request register
   // ---------------------------------------------------------------------
   logic                          in_valid_ff;
   logic [abtg_pkg::NOW_W-1:0]    now_ff;
   logic                          complete_ff;
   logic                          queued_ff;
   logic                          receiving_ff;
   logic                          offered_ff;
   logic [abtg_pkg::FRAME_W-1:0]  frame_len_ff;
   logic [abtg_pkg::EST_W-1:0]    est_ff;

   logic stage_go;     // the held item passes into the response register
   logic rsp_valid_ff;

   assign stage_go  = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || stage_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload needs no reset; load only on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         now_ff       <= req_now_ms;
         complete_ff  <= req_send_complete;
         queued_ff    <= req_queue_nonempty;
         receiving_ff <= req_radio_receiving;
         offered_ff   <= req_item_ready;
         frame_len_ff <= req_frame_len;
         est_ff       <= req_est_airtime_ms;
      end
   end

   // ---------------------------------------------------------------------
   // Send state
   // ---------------------------------------------------------------------
   logic          in_flight_ff,      in_flight_in;
   logic [TB-1:0] send_start_ff,     send_start_in;
   logic [TB-1:0] send_expiry_ff,    send_expiry_in;
   logic [TB-1:0] silence_until_ff,  silence_until_in;
   logic [TB-1:0] airtime_total_ff,  airtime_total_in;

   // ---------------------------------------------------------------------
   // Decision logic
   // ---------------------------------------------------------------------
   logic [WIDE_W-1:0]  now_wide;
   logic [TB-1:0]      now_t;
   logic [TB-1:0]      air_t;           // now minus start of the send
   logic [TB+3:0]      sil_prod;        // airtime times budget factor
   logic               settle_done;     // the send in flight completes this poll
   logic [TB-1:0]      exp_diff;
   logic [TB-1:0]      sil_diff;
   logic               expiry_passed;
   logic               silence_passed;
   logic [HALF_W:0]    est_x3;
   logic [WIDE_W-1:0]  est_half_wide;   // estimated airtime times 3/2
   logic               gate;
   logic               oversize;
   abtg_pkg::flags_type flags_in;
   logic [TB-1:0]      last_in;

   // mask the time to the internal width: zero-extend, then select
   assign now_wide = {{(WIDE_W - abtg_pkg::NOW_W){1'b0}}, now_ff};
   assign now_t    = now_wide[TB-1:0];

   assign air_t    = now_t - send_start_ff;
   assign sil_prod = {4'b0000, air_t} * {{TB{1'b0}}, budget_factor_ff};

   assign settle_done = in_flight_ff && complete_ff;

   // wrap-safe "has passed": signed difference strictly positive. A completion
   // in this poll moves the silence to now plus the product, so the difference
   // to now reduces to minus the product.
   assign exp_diff       = now_t - send_expiry_ff;
   assign sil_diff       = settle_done ? ({TB{1'b0}} - sil_prod[TB-1:0])
                                       : (now_t - silence_until_ff);
   assign expiry_passed  = (exp_diff != '0) && !exp_diff[TB-1];
   assign silence_passed = (sil_diff != '0) && !sil_diff[TB-1];

   assign est_x3        = {2'b00, est_ff} + {1'b0, est_ff, 1'b0};
   assign est_half_wide = {{(WIDE_W - HALF_W){1'b0}}, est_x3[HALF_W:1]};

   assign oversize = {1'b0, frame_len_ff} > {2'b00, max_frame_len_ff};

   always_comb begin
      in_flight_in     = in_flight_ff;
      send_start_in    = send_start_ff;
      send_expiry_in   = send_expiry_ff;
      silence_until_in = silence_until_ff;
      airtime_total_in = airtime_total_ff;
      flags_in         = '0;
      last_in          = '0;
      gate             = 1'b1;

      // settle the send in flight: completion wins over expiry
      if (in_flight_ff) begin
         if (complete_ff) begin
            last_in                = air_t;
            airtime_total_in       = airtime_total_ff + air_t;
            silence_until_in       = now_t + sil_prod[TB-1:0];
            in_flight_in           = 1'b0;
            flags_in.send_finished = 1'b1;
         end else if (expiry_passed) begin
            in_flight_in            = 1'b0;
            flags_in.send_timed_out = 1'b1;
         end else begin
            gate = 1'b0;
         end
      end

      // start check; the silence compare sees a silence set by this poll
      if (gate && queued_ff && silence_passed && !receiving_ff && offered_ff) begin
         if (oversize) begin
            flags_in.drop_oversize = 1'b1;
         end else begin
            send_start_in       = now_t;
            send_expiry_in      = now_t + est_half_wide[TB-1:0];
            in_flight_in        = 1'b1;
            flags_in.start_send = 1'b1;
         end
      end

      flags_in.busy_res = in_flight_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff     <= 1'b0;
         send_start_ff    <= '0;
         send_expiry_ff   <= '0;
         silence_until_ff <= '0;
         airtime_total_ff <= '0;
      end else if (stage_go) begin
         in_flight_ff     <= in_flight_in;
         send_start_ff    <= send_start_in;
         send_expiry_ff   <= send_expiry_in;
         silence_until_ff <= silence_until_in;
         airtime_total_ff <= airtime_total_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   abtg_pkg::flags_type                 flags_ff;
   logic [abtg_pkg::OUT_TIME_W-1:0]     last_ff;
   logic [abtg_pkg::OUT_TIME_W-1:0]     total_ff;
   logic [WIDE_W-1:0]                   last_wide;
   logic [WIDE_W-1:0]                   total_wide;

   assign last_wide  = {{(WIDE_W - TB){1'b0}}, last_in};
   assign total_wide = {{(WIDE_W - TB){1'b0}}, airtime_total_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the result while the consumer stalls
   always_ff @(posedge clock) begin
      if (stage_go) begin
         flags_ff <= flags_in;
         last_ff  <= last_wide[abtg_pkg::OUT_TIME_W-1:0];
         total_ff <= total_wide[abtg_pkg::OUT_TIME_W-1:0];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_start_send       = flags_ff.start_send;
   assign rsp_send_finished    = flags_ff.send_finished;
   assign rsp_send_timed_out   = flags_ff.send_timed_out;
   assign rsp_drop_oversize    = flags_ff.drop_oversize;
   assign rsp_busy_res         = flags_ff.busy_res;
   assign rsp_last_airtime_ms  = last_ff;
   assign rsp_total_airtime_ms = total_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // a send ends either by completion or by timeout, never both
   a_end_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(flags_ff.send_finished && flags_ff.send_timed_out))
      else $error("send both finished and timed out");

   // a started send is reported busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && flags_ff.start_send) |-> flags_ff.busy_res)
      else $error("start without busy");

   // the reported busy flag tracks the live send state
   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (flags_ff.busy_res == in_flight_ff))
      else $error("busy flag out of step with send state");

   // the airtime total moves only on a completed send
   a_total_moves: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (airtime_total_ff != $past(airtime_total_ff)))
         |-> (rsp_valid_ff && flags_ff.send_finished))
      else $error("airtime total changed without a completion");

endmodule : airtime_budget_tx_gate_unit

/* tb/sv/abtg_poll_checker.sv */
// Scoreboard for the airtime gate: predicts each poll decision and checks every response item.
`timescale 1ns / 100ps

module abtg_poll_checker
   import abtg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [NOW_W-1:0]        req_now_ms,
   input  logic                    req_send_complete,
   input  logic                    req_queue_nonempty,
   input  logic                    req_radio_receiving,
   input  logic                    req_item_ready,
   input  logic [FRAME_W-1:0]      req_frame_len,
   input  logic [EST_W-1:0]        req_est_airtime_ms,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_start_send,
   input  logic                    rsp_send_finished,
   input  logic                    rsp_send_timed_out,
   input  logic                    rsp_drop_oversize,
   input  logic [OUT_TIME_W-1:0]   rsp_last_airtime_ms,
   input  logic [OUT_TIME_W-1:0]   rsp_total_airtime_ms,
   input  logic                    rsp_busy_res,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int unsigned             fail_count,
   output int unsigned             n_pending
);

   localparam int unsigned TW = TIME_BITS_DEF;

   typedef struct packed {
      flags_type               flags;
      logic [OUT_TIME_W-1:0]   last_ms;
      logic [OUT_TIME_W-1:0]   total_ms;
   } poll_result_type;

   // Shadow copy of the gate state and its two limits
   logic                 sending = 1'b0;
   logic [TW-1:0]        tx_start_ms = '0;
   logic [TW-1:0]        tx_expiry_ms = '0;
   logic [TW-1:0]        quiet_until_ms = '0;
   logic [TW-1:0]        airtime_sum_ms = '0;
   logic [FACTOR_W-1:0]  factor = BUDGET_FACTOR_RST;
   logic [MAXLEN_W-1:0]  max_len = MAX_FRAME_LEN_RST;

   poll_result_type decisions_due[$];
   int unsigned  errors = 0;

   assign fail_count = errors;
   initial n_pending = 0;

   // Wrap-safe "t lies strictly in the past"
   function automatic logic elapsed(input logic [TW-1:0] now, input logic [TW-1:0] t);
      logic [TW-1:0] d;
      d = now - t;
      return (d != '0) && !d[TW-1];
   endfunction

   function automatic poll_result_type predict_poll(
      input logic [NOW_W-1:0]   now,
      input logic               done,
      input logic               queued,
      input logic               rx,
      input logic               offered,
      input logic [FRAME_W-1:0] flen,
      input logic [EST_W-1:0]   est
   );
      poll_result_type r;
      logic [TW-1:0] airtime;
      logic          may_start;
      r = '0;
      may_start = 1'b1;
      if (sending) begin
         if (done) begin
            airtime = now - tx_start_ms;
            r.flags.send_finished = 1'b1;
            r.last_ms = airtime;
            airtime_sum_ms = airtime_sum_ms + airtime;
            quiet_until_ms = now + airtime * {{(TW-FACTOR_W){1'b0}}, factor};
            sending = 1'b0;
         end else if (elapsed(now, tx_expiry_ms)) begin
            r.flags.send_timed_out = 1'b1;
            sending = 1'b0;
         end else begin
            may_start = 1'b0;
         end
      end
      if (may_start && queued && offered && !rx && elapsed(now, quiet_until_ms)) begin
         if (flen > {1'b0, max_len}) begin
            r.flags.drop_oversize = 1'b1;
         end else begin
            tx_start_ms = now;
            tx_expiry_ms = now + (({{(TW-EST_W){1'b0}}, est} * 3) >> 1);
            sending = 1'b1;
            r.flags.start_send = 1'b1;
         end
      end
      r.total_ms = airtime_sum_ms;
      r.flags.busy_res = sending;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      poll_result_type want;
      if (reset) begin
         sending = 1'b0;
         tx_start_ms = '0;
         tx_expiry_ms = '0;
         quiet_until_ms = '0;
         airtime_sum_ms = '0;
         factor = BUDGET_FACTOR_RST;
         max_len = MAX_FRAME_LEN_RST;
         decisions_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BUDGET_FACTOR: factor = csr_wdata[FACTOR_W-1:0];
               CSR_MAX_FRAME_LEN: max_len = csr_wdata[MAXLEN_W-1:0];
               default: ;
            endcase
         end
         // retire before predicting, so a stray response is never masked
         if (rsp_valid && rsp_ready) begin
            if (decisions_due.size() == 0) begin
               $error("response item with no decision due");
               errors++;
            end else begin
               want = decisions_due.pop_front();
               check_field("start_send", 32'(want.flags.start_send),
                           32'(rsp_start_send));
               check_field("send_finished", 32'(want.flags.send_finished),
                           32'(rsp_send_finished));
               check_field("send_timed_out", 32'(want.flags.send_timed_out),
                           32'(rsp_send_timed_out));
               check_field("drop_oversize", 32'(want.flags.drop_oversize),
                           32'(rsp_drop_oversize));
               check_field("last_airtime_ms", want.last_ms, rsp_last_airtime_ms);
               check_field("total_airtime_ms", want.total_ms, rsp_total_airtime_ms);
               check_field("busy_res", 32'(want.flags.busy_res), 32'(rsp_busy_res));
            end
         end
         if (req_valid && req_ready)
            decisions_due.push_back(predict_poll(req_now_ms, req_send_complete,
               req_queue_nonempty, req_radio_receiving, req_item_ready,
               req_frame_len, req_est_airtime_ms));
      end
      n_pending <= decisions_due.size();
   end

endmodule

/* tb/sv/tb_top.sv */
// Top of the airtime gate testbench: clock, reset, poll stimulus, response pacing and verdict.
`timescale 1ns / 100ps

module tb_top;
   import abtg_pkg::*;

   // Clock, reset and all block inputs start at known values
   logic                    clock;
   logic                    reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [NOW_W-1:0]        req_now_ms = '0;
   logic                    req_send_complete = 1'b0;
   logic                    req_queue_nonempty = 1'b0;
   logic                    req_radio_receiving = 1'b0;
   logic                    req_item_ready = 1'b0;
   logic [FRAME_W-1:0]      req_frame_len = '0;
   logic [EST_W-1:0]        req_est_airtime_ms = '0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_start_send;
   logic                    rsp_send_finished;
   logic                    rsp_send_timed_out;
   logic                    rsp_drop_oversize;
   logic [OUT_TIME_W-1:0]   rsp_last_airtime_ms;
   logic [OUT_TIME_W-1:0]   rsp_total_airtime_ms;
   logic                    rsp_busy_res;

   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   int unsigned             fail_count;
   int unsigned             n_pending;

   // Stimulus bookkeeping: the running dispatcher clock and the length limit in force
   logic [NOW_W-1:0]        t_now = '0;
   logic [MAXLEN_W-1:0]     lim_len = MAX_FRAME_LEN_RST;
   int unsigned             n_offered = 0;

   localparam int unsigned  N_PHASES = 6;
   localparam int unsigned  PHASE_ITEMS = 258;
   localparam int unsigned  HOLD_AT = 400;     // response count at which the long hold starts
   localparam int unsigned  HOLD_CYCLES = 300;

   airtime_budget_tx_gate_unit u_top (.*);

   abtg_poll_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the gate wedges; several times the slowest legal run
   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Offer one poll item and hold it until the gate takes it. Every third run of
   // 64 items is offered back-to-back, the others with random gaps between items.
   // Valid is only lowered when a gap follows, so back-to-back items keep it high.
   task automatic offer_poll(
      input logic [NOW_W-1:0]   now,
      input logic               done,
      input logic               queued,
      input logic               rx,
      input logic               offered,
      input logic [FRAME_W-1:0] flen,
      input logic [EST_W-1:0]   est
   );
      int unsigned gap;
      gap = ((n_offered / 64) % 3 == 0) ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_now_ms          <= now;
      req_send_complete   <= done;
      req_queue_nonempty  <= queued;
      req_radio_receiving <= rx;
      req_item_ready      <= offered;
      req_frame_len       <= flen;
      req_est_airtime_ms  <= est;
      do @(posedge clock); while (!req_ready);
      n_offered++;
   endtask

   // One random poll. Most items follow a plausible dispatcher: time creeps
   // forward by a few milliseconds, packets are usually queued and due, frames
   // mostly fit and airtime estimates are short, so sends start, finish, time
   // out and fall under silence over and over. A small share is pure noise
   // across every bit of every field, and half of that re-anchors the clock.
   task automatic random_poll();
      int unsigned        kind;
      logic [NOW_W-1:0]   now;
      logic [FRAME_W-1:0] flen;
      logic [EST_W-1:0]   est;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         now = $urandom();
         if ($urandom_range(0, 1) == 1)
            t_now = now;
         flen = FRAME_W'($urandom_range(0, 1023));
         est = EST_W'($urandom());
         offer_poll(now, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), flen, est);
      end else begin
         if (kind >= 96)
            t_now = t_now + NOW_W'($urandom_range(41, 2000));
         else if (kind >= 20)
            t_now = t_now + NOW_W'($urandom_range(1, 40));
         flen = ($urandom_range(0, 9) == 0) ? FRAME_W'($urandom_range(0, 1023))
                                            : FRAME_W'($urandom_range(0, lim_len));
         est = ($urandom_range(0, 19) == 0) ? EST_W'($urandom())
                                            : EST_W'($urandom_range(0, 30));
         offer_poll(t_now, $urandom_range(0, 3) == 0, $urandom_range(0, 9) != 0,
                    $urandom_range(0, 6) == 0, $urandom_range(0, 9) != 0, flen, est);
      end
   endtask

   // Stop offering and wait until every decision has come back, then let the
   // two-stage pipe settle
   task automatic drain_gate();
      req_valid <= 1'b0;
      do @(posedge clock); while (n_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write both limits on consecutive cycles; junk the unused upper bits of
   // the factor write, which the register must ignore
   task automatic program_limits(input logic [FACTOR_W-1:0] fac,
                                 input logic [MAXLEN_W-1:0] mlen);
      logic [CSR_DATA_W-FACTOR_W-1:0] junk;
      logic [31:0]                    rnd;
      rnd  = $urandom();
      junk = rnd[CSR_DATA_W-FACTOR_W-1:0];
      csr_we    <= 1'b1;
      csr_index <= CSR_BUDGET_FACTOR;
      csr_wdata <= {junk, fac};
      @(posedge clock);
      csr_index <= CSR_MAX_FRAME_LEN;
      csr_wdata <= mlen;
      @(posedge clock);
      csr_we    <= 1'b0;
      lim_len = mlen;
   endtask

   // Response side: stall before each item, with runs of 50 items taken at
   // full rate. Once, hold ready low for a long stretch while the sender keeps
   // offering, so both pipe registers fill and the request side backs up.
   initial begin
      int unsigned n_taken;
      int unsigned stall;
      n_taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (n_taken == HOLD_AT)
            stall = HOLD_CYCLES;
         else if ((n_taken / 50) % 3 == 0)
            stall = 0;
         else
            stall = $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         n_taken++;
      end
   end

   // Main sequence: reset, directed polls under the reset limits, then six
   // phases of random polls, each under its own pair of limits
   initial begin
      int unsigned         p;
      int unsigned         k;
      logic [FACTOR_W-1:0] fac;
      logic [MAXLEN_W-1:0] mlen;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a send starts from idle
      offer_poll(32'd100, 1'b0, 1'b1, 1'b0, 1'b1, 10'd10, 24'd20);
      // still in flight: no start is tried even with a packet due
      offer_poll(32'd110, 1'b0, 1'b1, 1'b0, 1'b1, 10'd10, 24'd20);
      // completion: measure airtime, silence keeps the next packet back
      offer_poll(32'd120, 1'b1, 1'b1, 1'b0, 1'b1, 10'd10, 24'd20);
      // silence ends exactly now, which is not yet past
      offer_poll(32'd220, 1'b0, 1'b1, 1'b0, 1'b1, 10'd10, 24'd20);
      // blocked by a receive, then by no packet due, then by an empty queue
      offer_poll(32'd221, 1'b0, 1'b1, 1'b1, 1'b1, 10'd10, 24'd20);
      offer_poll(32'd222, 1'b0, 1'b1, 1'b0, 1'b0, 10'd10, 24'd20);
      offer_poll(32'd223, 1'b0, 1'b0, 1'b0, 1'b1, 10'd10, 24'd20);
      // longest frame: dropped as oversize
      offer_poll(32'd224, 1'b0, 1'b1, 1'b0, 1'b1, 10'd1023, 24'd20);
      // frame exactly at the limit with the largest airtime estimate
      offer_poll(32'd225, 1'b0, 1'b1, 1'b0, 1'b1, 10'd255, 24'hFF_FFFF);
      offer_poll(32'd300, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0, 24'd0);
      // completion report with nothing in flight is ignored
      offer_poll(32'd301, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0, 24'd0);
      // empty frame, short expiry
      offer_poll(32'd700, 1'b0, 1'b1, 1'b0, 1'b1, 10'd0, 24'd4);
      // at the expiry itself the send is still live
      offer_poll(32'd706, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 24'd0);
      // completion and expiry together: completion wins
      offer_poll(32'd707, 1'b1, 1'b1, 1'b0, 1'b1, 10'd5, 24'd5);
      offer_poll(32'd800, 1'b0, 1'b1, 1'b0, 1'b1, 10'd5, 24'd2);
      // timeout frees the gate for a new send in the same poll
      offer_poll(32'd810, 1'b0, 1'b1, 1'b0, 1'b1, 10'd6, 24'd10);
      offer_poll(32'd815, 1'b1, 1'b1, 1'b0, 1'b1, 10'd6, 24'd10);
      // long airtime across the signed half-range, then a send across the wrap
      offer_poll(32'h7FFF_0000, 1'b0, 1'b1, 1'b0, 1'b1, 10'd8, 24'd32);
      offer_poll(32'h8000_0010, 1'b1, 1'b0, 1'b0, 1'b0, 10'd0, 24'd0);
      offer_poll(32'hFFFF_FFF0, 1'b0, 1'b1, 1'b0, 1'b1, 10'd8, 24'd64);
      offer_poll(32'h0000_0010, 1'b1, 1'b1, 1'b0, 1'b1, 10'd8, 24'd64);
      t_now = 32'h0000_0100;

      for (p = 0; p < N_PHASES; p++) begin
         case (p)
            0: begin fac = 4'd0;  mlen = 9'd1;   end
            1: begin fac = 4'd15; mlen = 9'd511; end
            2: begin fac = 4'd5;  mlen = 9'd255; end
            3: begin fac = 4'd1;  mlen = 9'd0;   end
            default: begin
               fac  = FACTOR_W'($urandom_range(0, 15));
               mlen = MAXLEN_W'($urandom_range(1, 511));
            end
         endcase
         // limits change only with the gate empty
         drain_gate();
         program_limits(fac, mlen);
         // run one phase close to the top of the time range to wrap the clock
         if (p == 1)
            t_now = 32'hFFFF_F000;
         for (k = 0; k < PHASE_ITEMS; k++)
            random_poll();
      end

      drain_gate();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
